/* hdl/smp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smp_pkg
// Shared types and constants of the splitter-based multiway partition engine.
// ---------------------------------------------------------------------------
package smp_pkg;

   localparam int MAX_SPLITTERS = 1024;
   localparam int IDX_W         = $clog2(MAX_SPLITTERS);
   localparam int NUM_W         = IDX_W + 1;
   localparam int VAL_W         = 64;
   localparam int CNT_W         = 25;
   localparam int MODE_W        = 3;
   localparam int DEPTH_W       = 1;

   localparam logic [CNT_W-1:0] MAX_ITEMS = CNT_W'(16777216);

   localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COUNT   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PREFIX  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SCATTER = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd5;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_COUNT,
      OP_PREFIX,
      OP_SCATTER,
      OP_READ,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [VAL_W-1:0]   value;
      logic [IDX_W-1:0]          index;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SRCH,
      ST_CMP,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_PRE_RD,
      ST_PRE_WR,
      ST_START_RD,
      ST_START_OUT
   } state_type;

endpackage

/* hdl/smp_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smp_front
// Accepts commands, decodes the mode and queues them for the back end.
// ---------------------------------------------------------------------------
module smp_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  hold,
   input  logic [smp_pkg::MODE_W-1:0]            req_mode,
   input  logic signed [smp_pkg::VAL_W-1:0]      req_value,
   input  logic [smp_pkg::IDX_W-1:0]             req_index,
   output logic                                  busy,
   output logic                                  cmd_valid,
   output smp_pkg::cmd_type                      cmd,
   input  logic                                  cmd_pop
);
   import smp_pkg::*;

   localparam int DEPTH = 2**DEPTH_W;

   cmd_type              q_ff [DEPTH];
   logic [DEPTH_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_W:0]     fill_ff, fill_in;
   logic                 push;
   cmd_type              dec;

   always_comb begin
      unique case (req_mode)
         MODE_LOAD:    dec.op = OP_LOAD;
         MODE_COUNT:   dec.op = OP_COUNT;
         MODE_PREFIX:  dec.op = OP_PREFIX;
         MODE_SCATTER: dec.op = OP_SCATTER;
         MODE_READ:    dec.op = OP_READ;
         MODE_CLEAR:   dec.op = OP_CLEAR;
         default:      dec.op = OP_NONE;
      endcase
      dec.value = req_value;
      dec.index = req_index;
   end

   assign busy      = hold || (fill_ff == (DEPTH_W+1)'(DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (DEPTH_W+1)'(push) - (DEPTH_W+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* hdl/smp_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smp_back
// Executes queued commands against the splitter, count, start and cursor
// memories: splitter loads, binary search, counter and cursor updates, prefix sweep, start reads and clear sweep.
// ---------------------------------------------------------------------------
module smp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [smp_pkg::NUM_W-1:0]         used_n,
   input  logic                              cmd_valid,
   input  smp_pkg::cmd_type                  cmd,
   output logic                              cmd_pop,
   output logic                              init_busy,
   output logic                              rsp_valid,
   output logic [smp_pkg::IDX_W-1:0]         rsp_bucket,
   output logic [smp_pkg::CNT_W-1:0]         rsp_position,
   output logic [smp_pkg::CNT_W-1:0]         rsp_first_slot
);
   import smp_pkg::*;

   logic [VAL_W-1:0]  spl_mem [MAX_SPLITTERS];
   logic [CNT_W-1:0]  cnt_mem [MAX_SPLITTERS];
   logic [CNT_W-1:0]  sta_mem [MAX_SPLITTERS];
   logic [CNT_W-1:0]  cur_mem [MAX_SPLITTERS];

   logic signed [VAL_W-1:0] spl_rd_ff;
   logic [CNT_W-1:0]  cnt_rd_ff, cur_rd_ff, sta_rd_ff;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic              init_ff, init_in;
   logic [IDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, ptr_ff, ptr_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic              out_v_in, out_v_ff;
   logic [IDX_W-1:0]  out_b_in, out_b_ff;
   logic [CNT_W-1:0]  out_p_in, out_p_ff, out_s_in, out_s_ff;

   logic              spl_we, cnt_we, pre_we;
   logic              spl_re, cnt_re, cur_re, sta_re, cur_we;
   logic [IDX_W-1:0]  spl_raddr, rd_addr, wr_addr;
   logic [CNT_W-1:0]  cnt_wdata, cur_wdata;
   logic [IDX_W:0]    mid_sum;
   logic [CNT_W:0]    acc_sum;
   logic [CNT_W-1:0]  cnt_inc, cur_inc, acc_next;
   logic [IDX_W-1:0]  last;

   assign last      = IDX_W'(used_n - 1'b1);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, cnt_rd_ff};
   assign acc_next  = (acc_sum > {1'b0, MAX_ITEMS}) ? MAX_ITEMS : acc_sum[CNT_W-1:0];
   assign cnt_inc   = (cnt_rd_ff >= MAX_ITEMS) ? MAX_ITEMS : cnt_rd_ff + 1'b1;
   assign cur_inc   = (cur_rd_ff >= MAX_ITEMS) ? MAX_ITEMS : cur_rd_ff + 1'b1;
   assign init_busy = init_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      init_in   = init_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      ptr_in    = ptr_ff;
      acc_in    = acc_ff;
      out_v_in  = 1'b0;
      out_b_in  = '0;
      out_p_in  = '0;
      out_s_in  = '0;
      cmd_pop   = 1'b0;
      spl_we    = 1'b0;
      spl_re    = 1'b0;
      spl_raddr = mid_sum[IDX_W:1];
      cnt_re    = 1'b0;
      cur_re    = 1'b0;
      sta_re    = 1'b0;
      cnt_we    = 1'b0;
      cur_we    = 1'b0;
      pre_we    = 1'b0;
      rd_addr   = lo_ff;
      wr_addr   = lo_ff;
      cnt_wdata = cnt_inc;
      cur_wdata = cur_inc;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               lo_in   = '0;
               hi_in   = last;
               ptr_in  = '0;
               acc_in  = '0;
               unique case (cmd.op)
                  OP_LOAD: begin
                     spl_we   = 1'b1;
                     out_v_in = 1'b1;
                  end
                  OP_COUNT, OP_SCATTER: state_in = ST_SRCH;
                  OP_PREFIX:            state_in = ST_PRE_RD;
                  OP_READ:              state_in = ST_START_RD;
                  OP_CLEAR:             state_in = ST_CLEAR;
                  default:              out_v_in = 1'b1;
               endcase
            end
         end
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            wr_addr   = ptr_ff;
            cnt_wdata = '0;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == IDX_W'(MAX_SPLITTERS - 1)) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
               out_v_in = !init_ff;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               spl_re   = 1'b1;
               mid_in   = mid_sum[IDX_W:1];
               state_in = ST_CMP;
            end else begin
               state_in = ST_UPD_RD;
            end
         end
         ST_CMP: begin
            if (cmd_ff.value < spl_rd_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = ST_SRCH;
         end
         ST_UPD_RD: begin
            cnt_re   = (cmd_ff.op == OP_COUNT);
            cur_re   = (cmd_ff.op == OP_SCATTER);
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cnt_we   = (cmd_ff.op == OP_COUNT);
            cur_we   = (cmd_ff.op == OP_SCATTER);
            out_v_in = 1'b1;
            out_b_in = lo_ff;
            out_p_in = (cmd_ff.op == OP_SCATTER) ? cur_rd_ff : '0;
            state_in = ST_IDLE;
         end
         ST_PRE_RD: begin
            cnt_re   = 1'b1;
            rd_addr  = ptr_ff;
            state_in = ST_PRE_WR;
         end
         ST_PRE_WR: begin
            pre_we    = 1'b1;
            wr_addr   = ptr_ff;
            cur_wdata = acc_ff;
            acc_in    = acc_next;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == last) begin
               state_in = ST_IDLE;
               out_v_in = 1'b1;
            end else begin
               state_in = ST_PRE_RD;
            end
         end
         ST_START_RD: begin
            sta_re   = 1'b1;
            rd_addr  = cmd_ff.index;
            state_in = ST_START_OUT;
         end
         ST_START_OUT: begin
            out_v_in = 1'b1;
            out_s_in = ({1'b0, cmd_ff.index} < used_n) ? sta_rd_ff : '0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         init_ff  <= 1'b1;
         ptr_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         ptr_ff   <= ptr_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      acc_ff   <= acc_in;
      out_b_ff <= out_b_in;
      out_p_ff <= out_p_in;
      out_s_ff <= out_s_in;
   end

   always_ff @(posedge clock) begin
      if (spl_we) begin
         spl_mem[cmd.index] <= cmd.value;
      end
      if (spl_re) begin
         spl_rd_ff <= spl_mem[spl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cur_we || pre_we) begin
         cur_mem[wr_addr] <= cur_wdata;
      end
      if (cur_re) begin
         cur_rd_ff <= cur_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pre_we) begin
         sta_mem[wr_addr] <= acc_ff;
      end
      if (sta_re) begin
         sta_rd_ff <= sta_mem[rd_addr];
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_bucket     = out_b_ff;
   assign rsp_position   = out_p_ff;
   assign rsp_first_slot = out_s_ff;

endmodule

/* hdl/splitter_multiway_partition_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// splitter_multiway_partition_top
// Splitter-based multiway partition engine.
// ---------------------------------------------------------------------------
// Commands enter through a two-deep queue and run one at a time; each gives
// one result, strobed by rsp_valid for a single cycle, in command order, and
// the receiver cannot stall. A count or scatter pops the queue, runs a binary
// search (one splitter memory read and one compare per step), ends the search,
// reads and writes the counter or cursor and sets the output register. A
// prefix pass does one count read and one start/cursor write per bucket; a
// clear zeroes all 1024 count entries, one count entry a cycle. After reset
// the count memory is swept to zero while busy stays high. Write splitter_count
// only while idle; 0 acts as 1 and values above 1024 act as 1024.
module splitter_multiway_partition_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [smp_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [smp_pkg::VAL_W-1:0]     req_value,
   input  logic [smp_pkg::IDX_W-1:0]            req_index,
   input  logic                                 csr_write_enable,
   input  logic [smp_pkg::NUM_W-1:0]            csr_write_data,
   output logic                                 rsp_valid,
   output logic [smp_pkg::IDX_W-1:0]            rsp_bucket,
   output logic [smp_pkg::CNT_W-1:0]            rsp_position,
   output logic [smp_pkg::CNT_W-1:0]            rsp_first_slot
);
   import smp_pkg::*;

   logic [NUM_W-1:0] count_ff;
   logic [NUM_W-1:0] used_n;
   logic             cmd_valid, cmd_pop, init_busy;
   cmd_type          cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= NUM_W'(MAX_SPLITTERS);
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         used_n = NUM_W'(1);
      end else if (count_ff > NUM_W'(MAX_SPLITTERS)) begin
         used_n = NUM_W'(MAX_SPLITTERS);
      end else begin
         used_n = count_ff;
      end
   end

   smp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .hold      (init_busy),
      .req_mode  (req_mode),
      .req_value (req_value),
      .req_index (req_index),
      .busy      (busy),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   smp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .used_n         (used_n),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_bucket     (rsp_bucket),
      .rsp_position   (rsp_position),
      .rsp_first_slot (rsp_first_slot)
   );

endmodule

/* verif/splitter_multiway_partition_top_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// splitter_multiway_partition_top_test
// Self-checking test of the splitter-based multiway partition engine. Loads a
// sorted splitter table, then runs count, prefix, scatter, read-start and
// clear commands under several splitter counts. A scoreboard class keeps its
// own copy of the splitters, counts, starts and cursors. It predicts each
// result in command order and compares every strobed result field by field.
// ---------------------------------------------------------------------------
module splitter_multiway_partition_top_test;
   import smp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_PER_PHASE = 58;
   localparam int LOAD_CAP = 32;

   typedef struct {
      logic [IDX_W-1:0] bucket;
      logic [CNT_W-1:0] position;
      logic [CNT_W-1:0] first_slot;
   } result_type;

   class partition_scoreboard;
      logic signed [VAL_W-1:0] splitters [MAX_SPLITTERS];
      logic [CNT_W-1:0] counts [MAX_SPLITTERS];
      logic [CNT_W-1:0] starts [MAX_SPLITTERS];
      logic [CNT_W-1:0] cursors [MAX_SPLITTERS];
      int buckets_in_use;
      result_type pending_results [$];
      int failures;

      function new();
         buckets_in_use = MAX_SPLITTERS;
         failures = 0;
         foreach (counts[i]) begin
            splitters[i] = '0;
            counts[i] = '0;
            starts[i] = '0;
            cursors[i] = '0;
         end
      endfunction

      function void set_splitter_count(logic [NUM_W-1:0] n);
         buckets_in_use = (n == 0) ? 1 : (n > MAX_SPLITTERS) ? MAX_SPLITTERS : int'(n);
      endfunction

      function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
         logic [CNT_W:0] s;
         s = a + b;
         return (s > MAX_ITEMS) ? MAX_ITEMS : s[CNT_W-1:0];
      endfunction

      function int find_bucket(logic signed [VAL_W-1:0] v);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = buckets_in_use - 1;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (v < splitters[mid]) hi = mid;
            else lo = mid + 1;
         end
         return lo;
      endfunction

      function void note_command(logic [MODE_W-1:0] mode, logic signed [VAL_W-1:0] v,
                                 logic [IDX_W-1:0] idx);
         result_type r;
         logic [CNT_W-1:0] acc;
         int b;
         r.bucket = '0;
         r.position = '0;
         r.first_slot = '0;
         case (mode)
            MODE_LOAD: begin
               splitters[idx] = v;
            end
            MODE_COUNT: begin
               b = find_bucket(v);
               r.bucket = IDX_W'(b);
               counts[b] = sat_add(counts[b], CNT_W'(1));
            end
            MODE_PREFIX: begin
               acc = '0;
               for (int i = 0; i < buckets_in_use; i++) begin
                  starts[i] = acc;
                  cursors[i] = acc;
                  acc = sat_add(acc, counts[i]);
               end
            end
            MODE_SCATTER: begin
               b = find_bucket(v);
               r.bucket = IDX_W'(b);
               r.position = cursors[b];
               cursors[b] = sat_add(cursors[b], CNT_W'(1));
            end
            MODE_READ: begin
               if (idx < buckets_in_use) r.first_slot = starts[idx];
            end
            MODE_CLEAR: begin
               foreach (counts[i]) counts[i] = '0;
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [IDX_W-1:0] bucket, logic [CNT_W-1:0] position,
                                 logic [CNT_W-1:0] first_slot);
         result_type e;
         if (pending_results.size() == 0) begin
            $display("%t: unexpected result bucket=%0d position=%0d start=%0d",
                     $realtime, bucket, position, first_slot);
            failures++;
            return;
         end
         e = pending_results.pop_front();
         if (bucket !== e.bucket) begin
            $display("%t: bucket expected %0d actual %0d", $realtime, e.bucket, bucket);
            failures++;
         end
         if (position !== e.position) begin
            $display("%t: position expected %0d actual %0d", $realtime, e.position, position);
            failures++;
         end
         if (first_slot !== e.first_slot) begin
            $display("%t: first_slot expected %0d actual %0d", $realtime,
                     e.first_slot, first_slot);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [MODE_W-1:0] req_mode = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic [IDX_W-1:0] req_index = '0;
   logic csr_write_enable = 1'b0;
   logic [NUM_W-1:0] csr_write_data = '0;
   logic rsp_valid;
   logic [IDX_W-1:0] rsp_bucket;
   logic [CNT_W-1:0] rsp_position;
   logic [CNT_W-1:0] rsp_first_slot;

   partition_scoreboard sb = new();
   logic signed [VAL_W-1:0] sorted_splitters [MAX_SPLITTERS];
   bit loaded [MAX_SPLITTERS];
   bit prefix_done = 0;
   bit search_ok = 0;
   bit idling = 1;
   int cycles = 0;

   splitter_multiway_partition_top DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_value(req_value),
      .req_index(req_index),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_bucket(rsp_bucket),
      .rsp_position(rsp_position),
      .rsp_first_slot(rsp_first_slot)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("splitter_multiway_partition_top_test NOT OK");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_bucket, rsp_position, rsp_first_slot);
   end

   function logic signed [VAL_W-1:0] rand_value();
      return {$urandom, $urandom};
   endfunction

   task automatic send(logic [MODE_W-1:0] mode, logic signed [VAL_W-1:0] v,
                       logic [IDX_W-1:0] idx);
      bit was_busy;
      if (idling && $urandom_range(99) < 32) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_value <= v;
      req_index <= idx;
      forever begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
         if (!was_busy) break;
      end
      sb.note_command(mode, v, idx);
      if (mode == MODE_LOAD) loaded[idx] = 1;
      if (mode == MODE_PREFIX) prefix_done = 1;
   endtask

   // hold until every result has come back and the engine is idle
   task automatic drain();
      bit idle_now;
      start <= 1'b0;
      forever begin
         @(negedge clock);
         idle_now = (sb.pending_results.size() == 0) && !busy;
         @(posedge clock);
         if (idle_now) break;
      end
   endtask

   // load the low part of the table; searches only run once every slot they may read is loaded
   task automatic write_splitter_count(logic [NUM_W-1:0] n);
      int used;
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= n;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_splitter_count(n);
      prefix_done = 0;
      search_ok = 1;
      used = sb.buckets_in_use;
      for (int i = 0; i + 1 < used; i++) begin
         if (!loaded[i]) begin
            if (i < LOAD_CAP) send(MODE_LOAD, sorted_splitters[i], IDX_W'(i));
            else search_ok = 0;
         end
      end
   endtask

   function logic signed [VAL_W-1:0] probe_value();
      logic signed [VAL_W-1:0] s;
      s = sorted_splitters[$urandom_range(sb.buckets_in_use - 1)];
      case ($urandom_range(3))
         0: return s - 1;
         1: return s;
         2: return s + 1;
         default: return rand_value();
      endcase
   endfunction

   task automatic random_commands();
      int pick;
      int idx;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
         pick = $urandom_range(99);
         if (pick < 35 && search_ok) begin
            send(MODE_COUNT, probe_value(), $urandom);
         end else if (pick < 65 || (pick < 75 && !prefix_done)) begin
            if (!prefix_done) send(MODE_PREFIX, rand_value(), $urandom);
            else if (search_ok) send(MODE_SCATTER, probe_value(), $urandom);
            else send(MODE_READ, rand_value(), $urandom);
         end else if (pick < 75) begin
            idx = $urandom_range(sb.buckets_in_use);
            if ($urandom_range(3) == 0) idx = $urandom_range(MAX_SPLITTERS - 1);
            send(MODE_READ, rand_value(), idx);
         end else if (pick < 82) begin
            send(MODE_PREFIX, rand_value(), $urandom);
         end else if (pick < 92) begin
            idx = $urandom_range(MAX_SPLITTERS - 1);
            send(MODE_LOAD, ($urandom_range(3) == 0) ? rand_value() : sorted_splitters[idx],
                 idx);
         end else if (pick < 96) begin
            send(MODE_CLEAR, rand_value(), $urandom);
         end else begin
            send(pick[0] ? MODE_SPARE_A : MODE_SPARE_B, rand_value(), $urandom);
         end
      end
   endtask

   initial begin
      logic signed [VAL_W-1:0] vals [$];
      logic [NUM_W-1:0] settings [$];
      for (int i = 0; i < MAX_SPLITTERS - 2; i++) vals.push_back(rand_value() >>> $urandom_range(63));
      vals.push_back({1'b1, {VAL_W-1{1'b0}}});
      vals.push_back({1'b0, {VAL_W-1{1'b1}}});
      vals.sort();
      foreach (sorted_splitters[i]) sorted_splitters[i] = vals[i];
      foreach (loaded[i]) loaded[i] = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // edge cases with a small table
      write_splitter_count(4);
      send(MODE_LOAD, sorted_splitters[MAX_SPLITTERS-1], MAX_SPLITTERS - 1);
      send(MODE_COUNT, {1'b1, {VAL_W-1{1'b0}}}, '0);
      send(MODE_COUNT, {1'b0, {VAL_W-1{1'b1}}}, '1);
      send(MODE_COUNT, -1, '0);
      send(MODE_COUNT, 0, '0);
      send(MODE_COUNT, sorted_splitters[1], '0);
      send(MODE_COUNT, sorted_splitters[1] - 1, '0);
      send(MODE_PREFIX, '0, '0);
      send(MODE_SCATTER, {1'b1, {VAL_W-1{1'b0}}}, '0);
      send(MODE_SCATTER, {1'b0, {VAL_W-1{1'b1}}}, '0);
      send(MODE_SCATTER, sorted_splitters[2], '0);
      send(MODE_READ, '1, 0);
      send(MODE_READ, '0, 3);
      send(MODE_READ, '0, 4);
      send(MODE_READ, '0, MAX_SPLITTERS - 1);
      send(MODE_SPARE_A, '1, '1);
      send(MODE_SPARE_B, '0, '0);
      send(MODE_CLEAR, '0, '0);
      send(MODE_COUNT, sorted_splitters[0], '0);
      send(MODE_PREFIX, '0, '0);
      send(MODE_READ, '0, 1);

      settings = '{11'd1, 11'd0, 11'd2, 11'd17, 11'd1024, 11'd1000, 11'd2047, 11'd5};
      foreach (settings[p]) begin
         write_splitter_count(settings[p]);
         idling = (p != 3);
         random_commands();
      end

      drain();
      repeat (50) @(posedge clock);
      if (sb.failures == 0 && sb.pending_results.size() == 0) begin
         $display("splitter_multiway_partition_top_test OK");
      end else begin
         $display("splitter_multiway_partition_top_test NOT OK");
      end
      $finish;
   end

endmodule
